// File: rtl/palette_texel_expander_top_assert.svh
// ----------------------------------------------------------------------------
// Palette texel expander assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PALETTE_TEXEL_EXPANDER_TOP_ASSERT_SVH
`define PALETTE_TEXEL_EXPANDER_TOP_ASSERT_SVH

// same-cycle implication
`define PTE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PTE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/pte_pkg.sv
// ----------------------------------------------------------------------------
// Palette texel expander package
// Payload types, register codes and the color formatting function.
// ----------------------------------------------------------------------------
package pte_pkg;

	localparam int PALETTE_ENTRIES_DEF = 256;
	localparam int ENTRY_W             = 24;
	localparam int CFG_IDX_W           = 2;
	localparam int CFG_DATA_W          = 8;

	localparam logic [7:0] KEY_INDEX    = 8'd255;
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

	localparam logic [1:0] MODE_RGBA = 2'd0;
	localparam logic [1:0] MODE_RGB  = 2'd1;
	localparam logic [1:0] MODE_RED  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_ENABLE  = 2'd1;

	typedef enum logic [0:0] {
		FUNC_LOAD    = 1'b0,
		FUNC_CONVERT = 1'b1
	} func_t;

	typedef struct packed {
		func_t      func;
		logic [7:0] index;
		logic [7:0] load_red;
		logic [7:0] load_green;
		logic [7:0] load_blue;
	} pix_req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} color_t;

	typedef struct packed {
		logic full;
		logic room;
	} q_status_t;

	// entry is {red, green, blue}; out-of-range lookups read as zero
	function automatic color_t format_color(
		input logic [ENTRY_W-1:0] entry,
		input logic               in_range,
		input logic               is_key,
		input logic [1:0]         mode,
		input logic               key_en
	);
		color_t              c;
		logic [ENTRY_W-1:0]  e;
		e = in_range ? entry : '0;
		c.red   = e[23:16];
		c.green = e[15:8];
		c.blue  = e[7:0];
		c.alpha = ALPHA_OPAQUE;
		priority if (mode == MODE_RED) begin
			c.green = '0;
			c.blue  = '0;
			c.alpha = '0;
		end else if (key_en && is_key) begin
			c = '0;
		end else if (mode == MODE_RGB) begin
			c.alpha = '0;
		end else begin
			c.alpha = ALPHA_OPAQUE;
		end
		return c;
	endfunction

endpackage

// File: rtl/palette_texel_expander_top.sv
// ----------------------------------------------------------------------------
// Palette texel expander
// Expands 8-bit palette indices to RGBA, RGB or red-only color from a
// 24-bit palette RAM loaded through the same request stream.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  pix     | pix_valid / pix_ready | pix (pix_req_t: load or convert)
//  col     | col_valid / col_ready | col (color_t)
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One request per cycle while the queue has room; the palette RAM's single
//  port serves one load write or one convert read per cycle. A convert
//  result is registered out of the RAM, formatted and pushed into the queue,
//  which presents it on col. Reset clears control state and config only;
//  the palette holds garbage until loaded, so no clearing pass is run. A
//  stalled col side is absorbed by a three-entry queue; pix_ready drops only
//  when the queue plus the in-flight lookup would overflow it.
// ----------------------------------------------------------------------------
module palette_texel_expander_top #(
	parameter int PALETTE_ENTRIES = pte_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pix_valid,
	output logic                           pix_ready,
	input  pte_pkg::pix_req_t              pix,
	output logic                           col_valid,
	input  logic                           col_ready,
	output pte_pkg::color_t                col,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pte_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pte_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pte_pkg::*;

	localparam int         AW         = $clog2(PALETTE_ENTRIES);
	localparam logic [8:0] ENTRIES_9  = 9'(PALETTE_ENTRIES);

	logic [1:0]         output_mode_q;
	logic               key_enable_q;
	logic               accept;
	logic               in_range;
	logic               ram_we;
	logic               ram_re;
	logic [ENTRY_W-1:0] ram_rdata;
	logic               valid_s1;
	logic               in_range_s1;
	logic               key_s1;
	color_t             color_s1;
	q_status_t          q_stat;

	assign cfg_ready = 1'b1;
	assign pix_ready = q_stat.room;
	assign accept    = pix_valid && pix_ready;
	assign in_range  = {1'b0, pix.index} < ENTRIES_9;
	assign ram_we    = accept && (pix.func == FUNC_LOAD) && in_range;
	assign ram_re    = accept && (pix.func == FUNC_CONVERT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_mode_q <= MODE_RGBA;
			key_enable_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_OUTPUT_MODE: output_mode_q <= cfg_data[1:0];
				CFG_KEY_ENABLE:  key_enable_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// one request per cycle, so a load always lands before any later read
	pte_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (PALETTE_ENTRIES)
	) u_palette (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (pix.index[AW-1:0]),
		.wdata ({pix.load_red, pix.load_green, pix.load_blue}),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ram_re;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			in_range_s1 <= in_range;
			key_s1      <= (pix.index == KEY_INDEX);
		end
	end

	assign color_s1 = format_color(ram_rdata, in_range_s1, key_s1,
		output_mode_q, key_enable_q);

	pte_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (color_s1),
		.in_flight (valid_s1),
		.status    (q_stat),
		.col_valid (col_valid),
		.col_ready (col_ready),
		.col       (col)
	);

`include "palette_texel_expander_top_assert.svh"

	`PTE_ASSERT_NOW(a_no_overflow, valid_s1, !q_stat.full, "lookup landed on a full queue")
	`PTE_ASSERT_NEXT(a_convert_lands, ram_re, valid_s1, "accepted convert lost before queue")
	`PTE_ASSERT_NOW(a_red_only, col_valid && (output_mode_q == MODE_RED),
		(col.green == 8'd0) && (col.blue == 8'd0) && (col.alpha == 8'd0),
		"red-only result carries green, blue or alpha")

endmodule

// File: rtl/pte_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module pte_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// File: rtl/pte_out_queue.sv
// ----------------------------------------------------------------------------
// Result queue
// Three-entry queue after the lookup stage; reports room for a new request.
// ----------------------------------------------------------------------------
module pte_out_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pte_pkg::color_t     push_data,
	input  logic                in_flight,
	output pte_pkg::q_status_t  status,
	output logic                col_valid,
	input  logic                col_ready,
	output pte_pkg::color_t     col
);
	import pte_pkg::*;

	localparam int QDEPTH = 3;

	color_t     slot [QDEPTH];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign pop       = col_valid && col_ready;
	assign col_valid = (count_q != 2'd0);
	assign col       = slot[rd_ptr_q];

	// in-flight lookup must always find a slot when it lands
	assign status.full = (count_q == 2'(QDEPTH));
	assign status.room = ({1'b0, count_q} + {2'b00, in_flight}) < 3'(QDEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			slot[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == 2'(QDEPTH - 1)) ? 2'd0 : wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == 2'(QDEPTH - 1)) ? 2'd0 : rd_ptr_q + 2'd1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: verif/palette_texel_expander_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette texel expander testbench
// A directed table loads and converts the palette extremes through every mode
// and key setting, then about a thousand random loads and converts follow.
// Both sides idle at random. Each color is checked field by field against a
// typed-in expectation or a palette mirror kept in the testbench.
// ----------------------------------------------------------------------------
module palette_texel_expander_top_tb;
	import pte_pkg::*;

	localparam int NUM_ENTRIES  = PALETTE_ENTRIES_DEF;
	localparam int DRAIN_CYCLES = 6;
	localparam int SEGMENTS     = 6;
	localparam int SEG_ITEMS    = 55;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	typedef enum logic {ROW_PIX, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                kind;
		pix_req_t                 req;
		logic [CFG_IDX_W-1:0]     reg_sel;
		logic [CFG_DATA_W-1:0]    reg_val;
		logic                     known;
		color_t                   want;
	} script_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  pix_valid = 1'b0;
	logic                  pix_ready;
	pix_req_t              pix = '0;
	logic                  col_valid;
	logic                  col_ready = 1'b0;
	color_t                col;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// side-band that travels with each request: typed-in expectation
	logic                  pix_known = 1'b0;
	color_t                pix_want = '0;

	// mirror of the block's state, updated at acceptance
	logic [ENTRY_W-1:0]    palette_mirror [NUM_ENTRIES];
	logic [1:0]            mode_shadow = MODE_RGBA;
	logic                  key_shadow = 1'b0;
	color_t                colors_due [$];
	color_t                want_col;

	logic [255:0]          loaded = '0;
	logic [7:0]            loaded_list [$];
	int                    send_pct = 0;
	int                    stall_pct = 0;
	int                    n_errors = 0;
	script_row_t           texel_script [$];

	palette_texel_expander_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.col_valid (col_valid),
		.col_ready (col_ready),
		.col       (col),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		col_ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic color_t expand_texel(logic [7:0] idx);
		color_t             c;
		logic [ENTRY_W-1:0] e;
		e = (int'(idx) < NUM_ENTRIES) ? palette_mirror[idx] : '0;
		c = {e, ALPHA_OPAQUE};
		// red-only ignores the key
		if (mode_shadow == MODE_RED)
			c = {e[23:16], 24'h000000};
		else if (key_shadow && idx == KEY_INDEX)
			c = '0;
		else if (mode_shadow == MODE_RGB)
			c.alpha = '0;
		return c;
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: col.%s expected %02h got %02h", $time, name, want, got);
			n_errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_OUTPUT_MODE)
					mode_shadow = cfg_data[1:0];
				else if (cfg_index == CFG_KEY_ENABLE)
					key_shadow = cfg_data[0];
			end
			if (pix_valid && pix_ready) begin
				if (pix.func == FUNC_LOAD) begin
					if (int'(pix.index) < NUM_ENTRIES)
						palette_mirror[pix.index] = {pix.load_red, pix.load_green, pix.load_blue};
				end else begin
					colors_due.push_back(pix_known ? pix_want : expand_texel(pix.index));
				end
			end
			if (col_valid && col_ready) begin
				if (colors_due.size() == 0) begin
					$display("%0t ns: color %08h with none expected", $time, col);
					n_errors++;
				end else begin
					want_col = colors_due.pop_front();
					check_field("red", want_col.red, col.red);
					check_field("green", want_col.green, col.green);
					check_field("blue", want_col.blue, col.blue);
					check_field("alpha", want_col.alpha, col.alpha);
				end
			end
		end
	end

	function automatic script_row_t pixel_row(func_t fn, logic [7:0] idx, logic [23:0] rgb,
			logic known = 1'b0, color_t want = '0);
		script_row_t s;
		s.kind      = ROW_PIX;
		s.req.func  = fn;
		s.req.index = idx;
		{s.req.load_red, s.req.load_green, s.req.load_blue} = rgb;
		s.reg_sel   = '0;
		s.reg_val   = '0;
		s.known     = known;
		s.want      = want;
		return s;
	endfunction

	function automatic script_row_t cfg_row(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
		script_row_t s;
		s         = pixel_row(FUNC_LOAD, 8'd0, 24'h000000);
		s.kind    = ROW_CFG;
		s.reg_sel = sel;
		s.reg_val = val;
		return s;
	endfunction

	task automatic push_pixel(pix_req_t r, logic known, color_t want);
		while ($urandom_range(99) < send_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		if (r.func == FUNC_LOAD && !loaded[r.index]) begin
			loaded[r.index] = 1'b1;
			loaded_list.push_back(r.index);
		end
		pix_valid <= 1'b1;
		pix       <= r;
		pix_known <= known;
		pix_want  <= want;
		do @(posedge clk); while (!pix_ready);
	endtask

	// holds the sender until every color is back and the pipe has emptied
	task automatic wait_quiet();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (colors_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
		wait_quiet();
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// converts only touch entries already loaded; 255 is loaded up front
	task automatic send_random_item();
		pix_req_t r;
		r.func = ($urandom_range(99) < 30) ? FUNC_LOAD : FUNC_CONVERT;
		{r.load_red, r.load_green, r.load_blue} = 24'($urandom);
		if (r.func == FUNC_LOAD)
			r.index = ($urandom_range(9) == 0) ? KEY_INDEX : 8'($urandom);
		else if ($urandom_range(99) < 15)
			r.index = KEY_INDEX;
		else
			r.index = loaded_list[$urandom_range(loaded_list.size() - 1)];
		push_pixel(r, 1'b0, '0);
	endtask

	initial begin
		texel_script.push_back(pixel_row(FUNC_LOAD, 8'd0, 24'h000000));
		texel_script.push_back(pixel_row(FUNC_LOAD, KEY_INDEX, 24'hFFFFFF));
		texel_script.push_back(pixel_row(FUNC_LOAD, 8'd1, 24'hA55AC3));
		texel_script.push_back(pixel_row(FUNC_LOAD, 8'd128, 24'h123456));
		texel_script.push_back(pixel_row(FUNC_CONVERT, 8'd0, 24'hFFFFFF, 1'b1, 32'h000000FF));
		texel_script.push_back(pixel_row(FUNC_CONVERT, KEY_INDEX, 24'h000000, 1'b1, 32'hFFFFFFFF));
		texel_script.push_back(pixel_row(FUNC_CONVERT, 8'd1, 24'h5A5A5A));
		texel_script.push_back(cfg_row(CFG_KEY_ENABLE, 8'h01));
		texel_script.push_back(pixel_row(FUNC_CONVERT, KEY_INDEX, 24'hFFFFFF, 1'b1, 32'h00000000));
		texel_script.push_back(pixel_row(FUNC_CONVERT, 8'd128, 24'h000000));
		texel_script.push_back(cfg_row(CFG_OUTPUT_MODE, {6'd0, MODE_RGB}));
		texel_script.push_back(pixel_row(FUNC_CONVERT, 8'd1, 24'hFFFFFF));
		texel_script.push_back(pixel_row(FUNC_CONVERT, KEY_INDEX, 24'h000000, 1'b1, 32'h00000000));
		texel_script.push_back(pixel_row(FUNC_CONVERT, 8'd0, 24'hFFFFFF, 1'b1, 32'h00000000));
		texel_script.push_back(cfg_row(CFG_OUTPUT_MODE, {6'd0, MODE_RED}));
		texel_script.push_back(pixel_row(FUNC_CONVERT, KEY_INDEX, 24'h000000, 1'b1, 32'hFF000000));
		texel_script.push_back(pixel_row(FUNC_CONVERT, 8'd1, 24'hFFFFFF));
		// write to an unmapped register index must change nothing
		texel_script.push_back(cfg_row(CFG_UNUSED, 8'hFF));
		texel_script.push_back(pixel_row(FUNC_CONVERT, KEY_INDEX, 24'h000000, 1'b1, 32'hFF000000));
		// undefined mode acts as rgba
		texel_script.push_back(cfg_row(CFG_OUTPUT_MODE, {6'd0, MODE_SPARE}));
		texel_script.push_back(pixel_row(FUNC_CONVERT, KEY_INDEX, 24'hFFFFFF, 1'b1, 32'h00000000));
		texel_script.push_back(pixel_row(FUNC_CONVERT, 8'd128, 24'h000000));
		texel_script.push_back(cfg_row(CFG_KEY_ENABLE, 8'h00));
		texel_script.push_back(pixel_row(FUNC_CONVERT, KEY_INDEX, 24'h000000, 1'b1, 32'hFFFFFFFF));
		texel_script.push_back(pixel_row(FUNC_LOAD, KEY_INDEX, 24'h010203));
		texel_script.push_back(pixel_row(FUNC_CONVERT, KEY_INDEX, 24'hFFFFFF));
		// load of an entry, then a read of the same entry as the next request
		texel_script.push_back(pixel_row(FUNC_LOAD, 8'd0, 24'hFF00FF));
		texel_script.push_back(pixel_row(FUNC_CONVERT, 8'd0, 24'h00FF00, 1'b1, 32'hFF00FFFF));
		texel_script.push_back(cfg_row(CFG_OUTPUT_MODE, {6'd0, MODE_RGBA}));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pct  = 35;
		stall_pct = 70;
		foreach (texel_script[i]) begin
			if (texel_script[i].kind == ROW_CFG)
				write_reg(texel_script[i].reg_sel, texel_script[i].reg_val);
			else
				push_pixel(texel_script[i].req, texel_script[i].known, texel_script[i].want);
		end

		for (int phase = 0; phase < 3; phase++) begin
			send_pct  = (phase == 0) ? 35 : (phase == 1) ? 70 : 0;
			stall_pct = (phase == 0) ? 70 : (phase == 1) ? 35 : 0;
			for (int seg = 0; seg < SEGMENTS; seg++) begin
				write_reg(CFG_OUTPUT_MODE, {6'($urandom_range(63)), 2'($urandom_range(3))});
				write_reg(CFG_KEY_ENABLE, {7'($urandom), 1'($urandom)});
				repeat (SEG_ITEMS) send_random_item();
			end
		end

		wait_quiet();
		if (n_errors == 0)
			$display("palette_texel_expander_top verification clean");
		else
			$display("palette_texel_expander_top verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("palette_texel_expander_top verification failed");
		$finish;
	end

endmodule
